// ===== src/dsp_adpcm_frame_decoder_defines.svh =====
// Assertion macros for the ADPCM frame decoder RTL.
`ifndef DSP_ADPCM_FRAME_DECODER_DEFINES_SVH
`define DSP_ADPCM_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define DAFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dafd assertion failed");
`define DAFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dafd assertion failed");
`else
`define DAFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DAFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/dafd_pkg.sv =====
// Types and constants of the ADPCM frame decoder.
`default_nettype none
package dafd_pkg;

  localparam int FRAME_SAMPLES = 14;
  localparam int NUM_REGS      = 8;
  localparam int SEL_W         = $clog2(NUM_REGS);
  localparam int CFG_IDX_W     = 4;
  localparam int COEF_W        = 64;
  localparam int SAMPLE_W      = 16;
  localparam int NIB_W         = 4;
  localparam int CNT_W         = 4;
  localparam int FRAC_BITS     = 11;
  localparam int ROUND_BIAS    = 1024;
  localparam int PROD_W        = 2 * SAMPLE_W;
  localparam int PSUM_W        = PROD_W + 1;
  localparam int QUOT_W        = PSUM_W - FRAC_BITS;
  localparam int ACC_W         = 24;

  typedef struct packed {
    logic load;
    logic mul;
    logic emit;
  } dafd_cmd_t;

  typedef struct packed {
    logic in_empty;
    logic out_free;
    logic last;
  } dafd_status_t;

endpackage
`default_nettype wire

// ===== src/dsp_adpcm_frame_decoder.sv =====
// Top level of the DSP ADPCM frame decoder.
// One 8-byte frame word in, up to fourteen 16-bit PCM words out. A frame is
// accepted in IDLE, then each sample runs the two coefficient-by-history
// multiplies in the MUL state and the sum, shift and saturation in the ACC
// state, which waits while the output is stalled; the next sample's
// multiplies need the history word just written. The result word sits in an
// output register, so the final sample of a frame may wait while the next
// frame is accepted. Coefficient writes are always ready.
`default_nettype none
module dsp_adpcm_frame_decoder #(
  parameter int CHANNELS = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           channel,
  input  logic [63:0]                    frame_data,
  input  logic [3:0]                     sample_count,
  input  logic                           restart,
  input  logic signed [15:0]             start_hist_newer,
  input  logic signed [15:0]             start_hist_older,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_channel,
  output logic signed [15:0]             pcm_sample,
  output logic                           last_of_frame,
  output logic                           bad_predictor,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dafd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dafd_pkg::COEF_W-1:0]    cfg_data
);
  import dafd_pkg::*;

  dafd_cmd_t    cmd;
  dafd_status_t status;

  assign cfg_ready = 1'b1;

  dafd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dafd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .channel          (channel),
    .frame_data       (frame_data),
    .sample_count     (sample_count),
    .restart          (restart),
    .start_hist_newer (start_hist_newer),
    .start_hist_older (start_hist_older),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_channel      (out_channel),
    .pcm_sample       (pcm_sample),
    .last_of_frame    (last_of_frame),
    .bad_predictor    (bad_predictor),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
`default_nettype wire

// ===== src/dafd_ctrl.sv =====
// Sequencer of the ADPCM frame decoder: accept, multiply, accumulate per sample.
`default_nettype none
`include "dsp_adpcm_frame_decoder_defines.svh"
module dafd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dafd_pkg::dafd_status_t status,
  output dafd_pkg::dafd_cmd_t    cmd
);
  import dafd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ACC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (!status.in_empty) state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? S_IDLE : S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DAFD_ASSERT_NEXT(a_frame_starts, clk, rst, accept && !status.in_empty, state == S_MUL)
  `DAFD_ASSERT_NEXT(a_mul_then_acc, clk, rst, state == S_MUL, state == S_ACC)
  `DAFD_ASSERT_NEXT(a_last_ends, clk, rst, cmd.emit && status.last, state == S_IDLE)

endmodule
`default_nettype wire

// ===== src/dafd_datapath.sv =====
// Datapath: coefficient registers, channel history, predictor and output word.
`default_nettype none
module dafd_datapath #(
  parameter int CHANNELS = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               channel,
  input  logic [63:0]                        frame_data,
  input  logic [3:0]                         sample_count,
  input  logic                               restart,
  input  logic signed [15:0]                 start_hist_newer,
  input  logic signed [15:0]                 start_hist_older,
  input  logic                               cfg_valid,
  input  logic [dafd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dafd_pkg::COEF_W-1:0]        cfg_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_channel,
  output logic signed [15:0]                 pcm_sample,
  output logic                               last_of_frame,
  output logic                               bad_predictor,
  input  dafd_pkg::dafd_cmd_t                cmd,
  output dafd_pkg::dafd_status_t             status
);
  import dafd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [COEF_W-1:0]          coef [NUM_REGS];
  logic signed [SAMPLE_W-1:0] hist_newer [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_older [CHANNELS];

  logic                       in_ch_ok;
  logic [CNT_W-1:0]           cnt_sat;
  logic [COEF_W-1:0]          coef_row;
  logic [CH_W-1:0]            in_idx;
  logic [CH_W-1:0]            ch_idx;

  logic                       chan;
  logic [55:0]                nib_sh;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           idx;
  logic [3:0]                 scale;
  logic                       bad;
  logic signed [SAMPLE_W-1:0] c0;
  logic signed [SAMPLE_W-1:0] c1;
  logic signed [PROD_W-1:0]   p0;
  logic signed [PROD_W-1:0]   p1;

  logic signed [PSUM_W-1:0]   psum;
  logic signed [QUOT_W-1:0]   quot;
  logic signed [ACC_W-1:0]    nib_ext;
  logic signed [ACC_W-1:0]    nib_scaled;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] sat;

  assign in_ch_ok = (int'(channel) < CHANNELS);
  assign cnt_sat  = (sample_count > CNT_W'(FRAME_SAMPLES)) ? CNT_W'(FRAME_SAMPLES)
                                                           : sample_count;
  assign coef_row = coef[{channel, frame_data[62:61]}];
  assign in_idx   = CH_W'(channel);
  assign ch_idx   = CH_W'(chan);

  assign status.in_empty = !in_ch_ok || (sample_count == '0);
  assign status.out_free = !out_valid || !out_stall;
  assign status.last     = ((idx + CNT_W'(1)) == cnt);

  // Step term is a multiple of 2^11, so it adds after the floor shift.
  assign psum       = {p0[PROD_W-1], p0} + {p1[PROD_W-1], p1} + PSUM_W'(ROUND_BIAS);
  assign quot       = psum[PSUM_W-1:FRAC_BITS];
  assign nib_ext    = {{(ACC_W-NIB_W){nib_sh[55]}}, nib_sh[55:52]};
  assign nib_scaled = nib_ext <<< scale;
  assign acc        = {{(ACC_W-QUOT_W){quot[QUOT_W-1]}}, quot} + nib_scaled;

  always_comb begin
    if (acc > ACC_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (acc < -ACC_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = acc[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) coef[i] <= '0;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef[cfg_index[SEL_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hist_newer[i] <= '0;
        hist_older[i] <= '0;
      end
    end else if (cmd.load && restart && in_ch_ok) begin
      hist_newer[in_idx] <= start_hist_newer;
      hist_older[in_idx] <= start_hist_older;
    end else if (cmd.emit) begin
      hist_newer[ch_idx] <= sat;
      hist_older[ch_idx] <= hist_newer[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan   <= channel;
      nib_sh <= frame_data[55:0];
      cnt    <= cnt_sat;
      idx    <= '0;
      scale  <= frame_data[59:56];
      bad    <= frame_data[63];
      c0     <= frame_data[60] ? coef_row[31:16] : coef_row[63:48];
      c1     <= frame_data[60] ? coef_row[15:0]  : coef_row[47:32];
    end else if (cmd.emit) begin
      nib_sh <= nib_sh << NIB_W;
      idx    <= idx + CNT_W'(1);
    end
    if (cmd.mul) begin
      p0 <= c0 * hist_newer[ch_idx];
      p1 <= c1 * hist_older[ch_idx];
    end
    if (cmd.emit) begin
      out_channel   <= chan;
      pcm_sample    <= sat;
      last_of_frame <= status.last;
      bad_predictor <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
